### hw/rtl/plid_pkg.sv
// shared types and constants for the positional list core
`timescale 1ns / 1ps

package plid_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned POS_W    = 5;
	localparam int unsigned ELEM_W   = 32;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned CNT_W    = 5;
	localparam int unsigned RDATA_W  = 32;
	localparam int unsigned CAP_W    = 5;
	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 40;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    exec;
		logic    ins;
		logic    del;
		logic    rd;
		status_t status;
	} plid_cmd_t;

	// datapath to controller
	typedef struct packed {
		opcode_t op;
		logic    full;
		logic    empty;
		logic    ins_pos_hi;
		logic    pos_hi;
	} plid_flag_t;

endpackage

### hw/rtl/plid_ctrl.sv
// command sequencer and result handshake for the positional list core
`timescale 1ns / 1ps

module plid_ctrl
	import plid_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  plid_flag_t flags,
	output plid_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd        = '0;
		cmd.status = STAT_OK;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_EXEC: begin
				cmd.exec = slot_free;
				case (flags.op)
					OP_INSERT: begin
						if (flags.full) begin
							cmd.status = STAT_FULL;
						end else if (flags.ins_pos_hi) begin
							cmd.status = STAT_RANGE;
						end else begin
							cmd.ins = slot_free;
						end
					end
					OP_DELETE, OP_READ: begin
						if (flags.empty) begin
							cmd.status = STAT_EMPTY;
						end else if (flags.pos_hi) begin
							cmd.status = STAT_RANGE;
						end else begin
							cmd.del = slot_free && (flags.op == OP_DELETE);
							cmd.rd  = slot_free && (flags.op == OP_READ);
						end
					end
					default: cmd.status = STAT_OK;
				endcase
			end
			default: s_tready = 1'b0;
		endcase
	end

	// a result is only written into a free or draining output slot
	a_exec_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> slot_free)
		else $error("result loaded over an unread beat");

	// at most one list operation per command
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.ins, cmd.del, cmd.rd}))
		else $error("more than one list operation issued");

	// list operations only with an execute strobe
	a_op_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins || cmd.del || cmd.rd) |-> cmd.exec)
		else $error("list operation without execute");

endmodule

### hw/rtl/plid_dp.sv
// shifting cell array, entry count, capacity register and result register
`timescale 1ns / 1ps

module plid_dp
	import plid_pkg::*;
#(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [OP_W-1:0]        in_op,
	input  logic [POS_W-1:0]       in_pos,
	input  logic signed [ELEM_W-1:0] in_elem,
	input  logic                   cfg_we,
	input  logic [CAP_W-1:0]       cfg_cap,
	input  plid_cmd_t              cmd,
	output plid_flag_t             flags,
	output logic [STAT_W-1:0]      out_status,
	output logic [CNT_W-1:0]       out_count,
	output logic [RDATA_W-1:0]     out_rdata
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

	logic [DATA_WIDTH-1:0] cells_q [DEPTH];
	logic [CW-1:0]         count_q, count_d;
	logic [CAP_W-1:0]      cap_q;
	opcode_t               op_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] elem_q;

	logic [PW-1:0] pos_x, cnt_x, cap_x, eff_cap;
	logic [AW-1:0] rd_idx;

	assign pos_x   = PW'(pos_q);
	assign cnt_x   = PW'(count_q);
	assign cap_x   = PW'(cap_q);
	// capacity saturates at the cell count
	assign eff_cap = (cap_x > PW'(DEPTH)) ? PW'(DEPTH) : cap_x;
	assign rd_idx  = AW'(pos_q);

	assign flags.op         = op_q;
	assign flags.full       = (cnt_x >= eff_cap);
	assign flags.empty      = (count_q == '0);
	assign flags.ins_pos_hi = (pos_x > cnt_x);
	assign flags.pos_hi     = (pos_x >= cnt_x);

	always_comb begin
		count_d = count_q;
		if (cmd.ins) begin
			count_d = count_q + CW'(1);
		end else if (cmd.del) begin
			count_d = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			count_q <= count_d;
			if (cfg_we) cap_q <= cfg_cap;
		end
	end

	// command latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode_t'(in_op);
			pos_q  <= in_pos;
			elem_q <= DATA_WIDTH'(in_elem);
		end
	end

	// each cell loads from its neighbor or takes the new element, all cells in the same cycle
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic ins_here, ins_shift, del_shift;
		assign ins_here  = cmd.ins && (PW'(i) == pos_x);
		assign ins_shift = cmd.ins && (PW'(i) > pos_x);
		assign del_shift = cmd.del && (PW'(i) >= pos_x);

		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (ins_here) begin
					cells_q[i] <= elem_q;
				end else if (del_shift) begin
					cells_q[i] <= cells_q[i+1];
				end
			end
		end else if (i == DEPTH - 1) begin : g_last
			always_ff @(posedge clk) begin
				if (ins_here) begin
					cells_q[i] <= elem_q;
				end else if (ins_shift) begin
					cells_q[i] <= cells_q[i-1];
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (ins_here) begin
					cells_q[i] <= elem_q;
				end else if (ins_shift) begin
					cells_q[i] <= cells_q[i-1];
				end else if (del_shift) begin
					cells_q[i] <= cells_q[i+1];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_status <= cmd.status;
			out_count  <= CNT_W'(count_d);
			out_rdata  <= cmd.rd ? RDATA_W'(cells_q[rd_idx]) : '0;
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= PW'(DEPTH))
		else $error("entry count above depth");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not bump the count");

	a_del_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del |=> (count_q == $past(count_q) - CW'(1)))
		else $error("delete did not drop the count");

endmodule

### hw/rtl/positional_list_insert_delete_core.sv
// top level of the positional list core: stream ports, sequencer and datapath
`timescale 1ns / 1ps

// ordered list of up to DEPTH signed words, one command per input beat
// input beat: opcode in s_tuser (insert, delete, read, no-op), position and
//   element in s_tdata; accepted when s_tvalid and s_tready are high
// output beat: status in m_tuser, count after the command and read data in
//   m_tdata; exactly one output beat for every input beat, in order
// cfg channel: one write of cfg_data sets the capacity limit (saturated at
//   DEPTH); cfg_ready is always high, write only while no command is in flight
// sequence: the input beat is latched in the idle state, then the execute state
//   loads the output register once the slot is free; the two-state sequencer
//   takes no new command until the last one has executed; the cell array shifts
//   all entries in parallel in the execute cycle
// stall: the result sits in the output register; the next input beat is still
//   taken, and its execute cycle waits until the held beat is taken
// reset: arst_n clears the count, sets the capacity limit to 16 and empties
//   the output register; cell contents are not cleared
module positional_list_insert_delete_core
	import plid_pkg::*;
#(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// slave side: command beats
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // position[4:0], element[36:5], zero pad
	input  logic [OP_W-1:0]        s_tuser,  // opcode[1:0]
	// master side: result beats
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // count[4:0], read_data[36:5], zero pad
	output logic [STAT_W-1:0]      m_tuser,  // status[1:0]
	// capacity limit write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CAP_W-1:0]       cfg_data
);

	plid_cmd_t  cmd;
	plid_flag_t flags;

	logic [CNT_W-1:0]   out_count;
	logic [RDATA_W-1:0] out_rdata;

	// capacity register is always writable
	assign cfg_ready = 1'b1;

	plid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.flags    (flags),
		.cmd      (cmd)
	);

	plid_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_op      (s_tuser),
		.in_pos     (s_tdata[POS_W-1:0]),
		.in_elem    (s_tdata[POS_W+ELEM_W-1:POS_W]),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_cap    (cfg_data),
		.cmd        (cmd),
		.flags      (flags),
		.out_status (m_tuser),
		.out_count  (out_count),
		.out_rdata  (out_rdata)
	);

	// pack the result beat, lowest field first
	assign m_tdata = {{(OUT_TDATA_W-CNT_W-RDATA_W){1'b0}}, out_rdata, out_count};

endmodule
